// ===== rtl/srpq_pkg.sv =====
package srpq_pkg;

    // request codes carried on the mode field
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    // status of one finished request, sequencer to output stage
    typedef struct packed {
        logic dq_valid;
        err_t error;
        logic is_empty;
        logic is_full;
    } status_t;

endpackage

// ===== rtl/srpq_ram.sv =====
module srpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/srpq_seq.sv =====
module srpq_seq #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = $clog2(DEPTH),
    parameter int CW          = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // request side
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  logic signed [31:0]     value,
    // finished request
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic [31:0]            res_value,
    output logic [CW-1:0]          res_count,
    output srpq_pkg::status_t      res_status,
    // entry memory
    output logic                   mem_we,
    output logic [AW-1:0]          mem_waddr,
    output logic [VALUE_WIDTH-1:0] mem_wdata,
    output logic [AW-1:0]          mem_raddr,
    input  logic [VALUE_WIDTH-1:0] mem_rdata
);

    localparam int SW = AW + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ_RD,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [31:0]            out_reg, out_next;
    logic                   dq_reg, dq_next;
    srpq_pkg::err_t         err_reg, err_next;

    logic [VALUE_WIDTH-1:0] in_val;
    logic [SW-1:0]          tail_sum;
    logic [AW-1:0]          tail;
    logic [AW-1:0]          idx_prev;
    logic                   is_full;
    logic                   moves_up;

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
        logic [AW-1:0] r;
        if (i == '0)
        begin
            r = AW'(DEPTH - 1);
        end
        else
        begin
            r = i - 1'b1;
        end
        return r;
    endfunction

    // narrow to the stored width, zero fill when wider
    assign in_val   = VALUE_WIDTH'({{VALUE_WIDTH{1'b0}}, value});
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign idx_prev = ring_prev(idx_reg);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign moves_up = $signed(val_reg) > $signed(mem_rdata);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        out_next   = out_reg;
        dq_next    = dq_reg;
        err_next   = err_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = val_reg;
        mem_raddr  = ring_prev(idx_prev);
        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = head_reg;
                if (in_valid)
                begin
                    out_next = '0;
                    dq_next  = 1'b0;
                    err_next = srpq_pkg::ERR_NONE;
                    if (mode == srpq_pkg::MODE_DEQ)
                    begin
                        if (count_reg == '0)
                        begin
                            err_next   = srpq_pkg::ERR_EMPTY;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_DEQ_RD;
                        end
                    end
                    else if (is_full)
                    begin
                        err_next   = srpq_pkg::ERR_FULL;
                        state_next = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = in_val;
                        head_next  = '0;
                        count_next = CW'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // fetch the predecessor of the new tail
                        mem_raddr  = ring_prev(tail);
                        idx_next   = tail;
                        val_next   = in_val;
                        count_next = count_reg + 1'b1;
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_DEQ_RD:
            begin
                out_next   = 32'({{32{mem_rdata[VALUE_WIDTH-1]}}, mem_rdata});
                dq_next    = 1'b1;
                count_next = count_reg - 1'b1;
                if (count_reg == CW'(1) || head_reg == AW'(DEPTH - 1))
                begin
                    head_next = '0;
                end
                else
                begin
                    head_next = head_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_SHIFT:
            begin
                mem_we = 1'b1;
                if (idx_reg != head_reg && moves_up)
                begin
                    // predecessor slides down one slot, keep walking
                    mem_wdata = mem_rdata;
                    idx_next  = idx_prev;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            val_reg   <= '0;
            out_reg   <= '0;
            dq_reg    <= 1'b0;
            err_reg   <= srpq_pkg::ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            val_reg   <= val_next;
            out_reg   <= out_next;
            dq_reg    <= dq_next;
            err_reg   <= err_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res_value  = out_reg;
    assign res_count  = count_reg;
    // dq_valid, error, is_empty, is_full
    assign res_status = {dq_reg, err_reg, (count_reg == '0), is_full};

endmodule

// ===== rtl/sorted_ring_priority_queue_top.sv =====
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------------
// request   | in_valid, in_ready  | mode, value
// response  | rsp_valid, rsp_ready| out_value, out_valid, error, count, is_empty,
//           |                     | is_full
//
// one word in, one word out; after acceptance a dequeue reads the head, an
// enqueue walks the new value up past the stored entries it outranks (0 to
// DEPTH-1), a rejected request or a first entry goes straight to the result
// in_ready is low while a request is in work or while its result waits on a
// stalled response register, and rises the cycle after the result moves on
// reset clears head, count and handshake state; the entry memory is not cleared
module sorted_ring_priority_queue_top #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic signed [31:0]               value,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic signed [31:0]               out_value,
    output logic                             out_valid,
    output logic [1:0]                       error,
    output logic [$clog2(DEPTH + 1)-1:0]     count,
    output logic                             is_empty,
    output logic                             is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer to response register
    logic                   res_valid;
    logic                   res_ready;
    logic [31:0]            res_value;
    logic [CW-1:0]          res_count;
    srpq_pkg::status_t      res_status;

    // entry memory ports
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    // response register
    logic                   rsp_valid_reg;
    logic [31:0]            value_reg;
    logic [CW-1:0]          count_reg;
    srpq_pkg::status_t      status_reg;

    srpq_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .value      (value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_value  (res_value),
        .res_count  (res_count),
        .res_status (res_status),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // sorted ring of entries, head holds the largest
    srpq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // load the response register whenever it is empty or being drained
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            value_reg  <= res_value;
            count_reg  <= res_count;
            status_reg <= res_status;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign out_value = value_reg;
    assign out_valid = status_reg.dq_valid;
    assign error     = status_reg.error;
    assign count     = count_reg;
    assign is_empty  = status_reg.is_empty;
    assign is_full   = status_reg.is_full;

endmodule

// ===== tb/sv/tb_sorted_ring_priority_queue_top.sv =====
`timescale 1ns / 1ps

module tb_sorted_ring_priority_queue_top;

    // block size as built, default parameters
    localparam int DEPTH        = 64;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    // long receiver hold-off, enough for the request side to back up
    localparam int HOLD_CYCLES  = 400;
    // cycles with no word moving on either channel before we give up;
    // well above the hold-off plus the slowest enqueue
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_WORDS = 1400;

    // one expected response word
    typedef struct {
        logic signed [31:0] value;
        logic               valid;
        srpq_pkg::err_t     error;
        logic [CNT_W-1:0]   count;
        logic               empty;
        logic               full;
    } pq_rsp_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic               mode      = srpq_pkg::MODE_ENQ;
    logic signed [31:0] value     = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic signed [31:0] out_value;
    logic               out_valid;
    logic [1:0]         error;
    logic [CNT_W-1:0]   count;
    logic               is_empty;
    logic               is_full;

    // shadow of the queue contents, kept in descending order from the head
    int      sorted_vals[$];
    pq_rsp_t pending_rsp_q[$];

    int words_sent    = 0;
    int results_seen  = 0;
    int fail_count    = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    int hold_requested = 0;
    int hold_granted   = 0;

    sorted_ring_priority_queue_top #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (32)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .out_value (out_value),
        .out_valid (out_valid),
        .error     (error),
        .count     (count),
        .is_empty  (is_empty),
        .is_full   (is_full)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // queue behaviour: a new value lands behind every stored value that is
    // greater or equal, which is where the bubbling stops, so equal values
    // leave in arrival order; a dequeue takes the head, the largest value
    // ------------------------------------------------------------------
    function automatic pq_rsp_t apply_request(input logic m, input logic signed [31:0] v);
        pq_rsp_t r;
        int      pos;
        r.value = '0;
        r.valid = 1'b0;
        r.error = srpq_pkg::ERR_NONE;
        if (m == srpq_pkg::MODE_ENQ) begin
            if (sorted_vals.size() >= DEPTH) begin
                r.error = srpq_pkg::ERR_FULL;
            end
            else begin
                pos = 0;
                while (pos < sorted_vals.size() && sorted_vals[pos] >= int'(v))
                    pos++;
                sorted_vals.insert(pos, int'(v));
            end
        end
        else begin
            if (sorted_vals.size() == 0) begin
                r.error = srpq_pkg::ERR_EMPTY;
            end
            else begin
                r.value = sorted_vals.pop_front();
                r.valid = 1'b1;
            end
        end
        r.count = CNT_W'(sorted_vals.size());
        r.empty = (sorted_vals.size() == 0);
        r.full  = (sorted_vals.size() == DEPTH);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: responses are checked first, then an accepted request word
    // is run through the shadow queue; both sample pre-edge values
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pq_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_seen++;
                if (pending_rsp_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: response word with nothing expected, out_value %0h",
                             $time, out_value);
                end
                else
                begin
                    want = pending_rsp_q.pop_front();
                    check_field("out_value", want.value, out_value);
                    check_field("out_valid", 32'(want.valid), 32'(out_valid));
                    check_field("error", 32'(want.error), 32'(error));
                    check_field("count", 32'(want.count), 32'(count));
                    check_field("is_empty", 32'(want.empty), 32'(is_empty));
                    check_field("is_full", 32'(want.full), 32'(is_full));
                end
            end
            if (in_valid && in_ready)
            begin
                want = apply_request(mode, value);
                pending_rsp_q.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall style changes every so often (always ready, coin
    // toss, short stall bursts); a requested hold-off is counted down here
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        static int style      = 0;
        static int style_left = 0;
        static int stall_left = 0;
        static int hold_left  = 0;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (hold_requested != hold_granted)
            begin
                hold_granted = hold_requested;
                hold_left    = HOLD_CYCLES;
            end
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 2);
                style_left = $urandom_range(40, 160);
            end
            style_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (style == 0)
                rsp_ready <= 1'b1;
            else if (style == 1)
                rsp_ready <= 1'($urandom_range(0, 1));
            else
            begin
                // short stall bursts between ready stretches
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_ready <= 1'b0;
                end
                else
                begin
                    rsp_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 6);
                end
            end
        end
    end

    // watchdog on cycles in which no word moves on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("** sorted_ring_priority_queue_top: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender: offers one word and waits for it to be taken; words go out
    // in bursts of random length with random gaps between them, a gap of
    // zero keeps valid high straight into the next burst
    // ------------------------------------------------------------------
    task automatic send_word(input logic m, input logic signed [31:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // sender pauses until every response owed has come back
    task automatic wait_drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (results_seen < words_sent) @(posedge clk);
    endtask

    // value mix: full range, a narrow band for ties, the extremes, and a band from -500 to 500
    function automatic logic signed [31:0] pick_value(input int flavour);
        logic signed [31:0] v;
        case (flavour)
            0:       v = $urandom;
            1:       v = $signed($urandom_range(0, 8)) - 4;
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'sh7fff_ffff;
                    1:       v = 32'sh8000_0000;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            default: v = $signed($urandom_range(0, 1000)) - 500;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes, ties, dequeue while empty and refill after draining
    task automatic test_directed();
        send_word(srpq_pkg::MODE_DEQ, 32'sh1234_5678);
        send_word(srpq_pkg::MODE_ENQ, 0);
        send_word(srpq_pkg::MODE_ENQ, 32'sh7fff_ffff);
        send_word(srpq_pkg::MODE_ENQ, 32'sh8000_0000);
        send_word(srpq_pkg::MODE_ENQ, -1);
        send_word(srpq_pkg::MODE_ENQ, 1);
        send_word(srpq_pkg::MODE_ENQ, 32'sh5555_5555);
        send_word(srpq_pkg::MODE_ENQ, 7);
        send_word(srpq_pkg::MODE_ENQ, 7);
        repeat (8) send_word(srpq_pkg::MODE_DEQ, $urandom);
        // queue now empty with head back at the start; dequeue while empty again
        send_word(srpq_pkg::MODE_DEQ, 0);
        send_word(srpq_pkg::MODE_ENQ, 32'sh2aaa_aaaa);
        send_word(srpq_pkg::MODE_DEQ, 0);
    endtask

    // ascending values so each one climbs to the head, then overflow
    task automatic test_fill_overflow();
        for (int i = 0; i < DEPTH; i++)
            send_word(srpq_pkg::MODE_ENQ, -1000 + i * 37);
        repeat (3) send_word(srpq_pkg::MODE_ENQ, pick_value(0));
        wait_drain();
        repeat (DEPTH) send_word(srpq_pkg::MODE_DEQ, 0);
        send_word(srpq_pkg::MODE_DEQ, 0);
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_back_pressure();
        hold_requested++;
        @(posedge clk);
        for (int i = 0; i < 8; i++)
            send_word((i % 3 == 2) ? srpq_pkg::MODE_DEQ : srpq_pkg::MODE_ENQ,
                      pick_value($urandom_range(0, 3)));
        wait_drain();
    endtask

    // phases biased to fill, hover or drain so the queue visits full and
    // empty and the ring wraps many times
    task automatic test_random();
        int left;
        int run_len;
        int enq_pct;
        int flavour;
        left = RANDOM_WORDS;
        while (left > 0)
        begin
            run_len = $urandom_range(40, 120);
            if (run_len > left)
                run_len = left;
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 50;
                default: enq_pct = 15;
            endcase
            flavour = $urandom_range(0, 3);
            for (int i = 0; i < run_len; i++)
            begin
                if ($urandom_range(0, 99) < enq_pct)
                    send_word(srpq_pkg::MODE_ENQ,
                              pick_value(($urandom_range(0, 4) == 0) ?
                                         $urandom_range(0, 3) : flavour));
                else
                    send_word(srpq_pkg::MODE_DEQ, $urandom);
            end
            left -= run_len;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_overflow();
        test_back_pressure();
        test_random();

        wait_drain();
        // quiet tail, anything arriving now is unexpected
        repeat (DEPTH + 16) @(posedge clk);
        if (pending_rsp_q.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d expected response words never arrived",
                     $time, pending_rsp_q.size());
        end

        if (fail_count == 0)
            $display("** sorted_ring_priority_queue_top: PASSED **");
        else
            $display("** sorted_ring_priority_queue_top: FAILED **");
        $finish;
    end

endmodule
